[src/frm_pkg.sv]
// frm_pkg: shared types and constants for the frame rate monitor.
// Depends on nothing; imported by frame_rate_monitor.
package frm_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned RateW  = 16;
  localparam int unsigned IntvW  = 24;
  localparam int unsigned CfgW   = 24;
  localparam int unsigned CfgIdxW = 2;

  // microseconds per second, walked MSB first by the serial multiplier
  localparam int unsigned UsPerSecW = 20;
  localparam logic [UsPerSecW-1:0] UsPerSec = 20'd1000000;

  // product width: delta * 1e6 fits in 52 bits; the 8.8 scale adds 8 more
  localparam int unsigned ProdW = CountW + UsPerSecW;
  localparam int unsigned FracW = 8;
  // quotient bits resolved by the divider; anything above is overflow
  localparam int unsigned QuoW  = RateW + 1;
  localparam int unsigned CntW  = 5;

  typedef enum logic [1:0] {
    CFG_TARGET_RATE = 2'd0,
    CFG_RATE_TOL    = 2'd1,
    CFG_MIN_INTV    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_OVF,
    ST_DIV,
    ST_DONE
  } frm_state_t;

endpackage

[src/frame_rate_monitor.sv]
// frame_rate_monitor: top level, rate measurement with a serial multiplier
// and a serial restoring divider. Depends on frm_pkg.
//
// Usage:
//   in_*  channel: one beat per sensor poll (frame count, timestamp in us).
//   out_* channel: exactly one result beat per input beat, in order.
//   cfg_* port   : target rate, tolerance and minimum interval; write only
//                  while the block is idle.
// Steps per poll:
//   - first poll, or interval not exceeded: accept, check, done.
//   - rate measured: the multiply by 1e6 walks its 20 constant
//     bits, one per cycle; one state checks for a quotient of 17 bits or
//     more, which saturates and skips the divider;
//     else the divider retires one quotient bit per cycle, 17 bits in all.
//   A new poll is accepted once the previous one has moved to the output
//   register, so the next poll overlaps a result waiting on out_ready.
// Stall: if the output register is full and out_ready is low when a
//   result is done, the engine holds in its final state and the committed
//   state (last sample, fault) is not updated until the result beat is loaded.
// Reset: clears the sample history, first-poll flag and fault flag, loads
//   the register defaults (30.0 fps, 4.0 fps, 1 s) and empties the output.

module frame_rate_monitor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [frm_pkg::CountW-1:0] in_frame_count,
  input  logic [frm_pkg::TimeW-1:0]  in_timestamp_us,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_rate_valid,
  output logic [frm_pkg::RateW-1:0]  out_measured_rate,
  output logic                       out_rate_fault,
  output logic                       out_fault_changed,
  input  logic                       cfg_we,
  input  logic [frm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [frm_pkg::CfgW-1:0]   cfg_wdata
);
  import frm_pkg::*;

  // configuration
  logic [RateW-1:0] target_r, tol_r;
  logic [IntvW-1:0] min_intv_r;

  // committed history
  logic [CountW-1:0] last_count_r;
  logic [TimeW-1:0]  last_time_r;
  logic              seen_first_r;
  logic              fault_r;

  // per-poll working registers
  logic [CountW-1:0] cur_count_r, delta_r;
  logic [TimeW-1:0]  cur_time_r, elapsed_r;
  logic              meas_r;      // a rate is measured on this poll
  logic              store_r;     // sample is committed on this poll
  logic              ovf_r;       // quotient >= 2^17
  logic [ProdW-1:0]  acc_r;       // delta * 1e6
  logic [TimeW-1:0]  rem_r;       // divider partial remainder
  logic [QuoW-1:0]   quo_r;       // quotient bits, shifted in LSB side
  logic [QuoW-1:0]   dvd_r;       // low dividend bits, shifted out MSB first
  logic [CntW-1:0]   cnt_r;

  // output register
  logic              out_valid_r;
  logic              o_rate_valid_r, o_fault_r, o_changed_r;
  logic [RateW-1:0]  o_rate_r;

  frm_state_t state_r, state_nxt;

  // control decode
  logic accept, load_out, mul_step, ovf_step, div_step, check_step;

  // combinational datapath
  logic [TimeW:0]    trial;
  logic              trial_ok;
  logic              intv_exceeded;
  logic [TimeW-1:0]  acc_hi;
  logic              acc_ovf;
  logic [QuoW-1:0]   lo_bound, hi_bound;
  logic              low_fail, high_fail, new_fault;
  logic [RateW-1:0]  rate_sat;

  // ---------------------------------------------------------------------
  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = (seen_first_r && intv_exceeded) ? ST_MUL : ST_DONE;
      ST_MUL:   if (cnt_r == CntW'(0)) state_nxt = ST_OVF;
      ST_OVF:   state_nxt = acc_ovf ? ST_DONE : ST_DIV;
      ST_DIV:   if (cnt_r == CntW'(0)) state_nxt = ST_DONE;
      ST_DONE:  if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = 1'b0;
    check_step = 1'b0;
    mul_step   = 1'b0;
    ovf_step   = 1'b0;
    div_step   = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready   = 1'b1;
      ST_CHECK: check_step = 1'b1;
      ST_MUL:   mul_step   = 1'b1;
      ST_OVF:   ovf_step   = 1'b1;
      ST_DIV:   div_step   = 1'b1;
      ST_DONE:  load_out   = !out_valid_r || out_ready;
      default:  in_ready   = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // datapath logic
  assign intv_exceeded = elapsed_r > {{(TimeW-IntvW){1'b0}}, min_intv_r};

  // overflow when floor(num / 2^17) >= elapsed, num = acc << 8
  assign acc_hi  = TimeW'(acc_r[ProdW-1:QuoW-FracW]);
  assign acc_ovf = acc_hi >= elapsed_r;

  // restoring division step
  assign trial    = {rem_r, dvd_r[QuoW-1]} - {1'b0, elapsed_r};
  assign trial_ok = !trial[TimeW];

  assign lo_bound = {1'b0, target_r} - {1'b0, tol_r};
  assign hi_bound = {1'b0, target_r} + {1'b0, tol_r};

  // overflow means the quotient is above any possible upper bound
  assign low_fail  = !ovf_r && (target_r >= tol_r) && (quo_r < lo_bound);
  assign high_fail = ovf_r || (quo_r > hi_bound) ||
                     ((quo_r == hi_bound) && (rem_r != '0));
  assign new_fault = meas_r ? (low_fail || high_fail) : fault_r;
  assign rate_sat  = (ovf_r || quo_r[QuoW-1]) ? {RateW{1'b1}} : quo_r[RateW-1:0];

  // ---------------------------------------------------------------------
  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seen_first_r <= 1'b0;
      fault_r      <= 1'b0;
      last_count_r <= '0;
      last_time_r  <= '0;
      out_valid_r  <= 1'b0;
      target_r     <= RateW'(7680);
      tol_r        <= RateW'(1024);
      min_intv_r   <= IntvW'(1000000);
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_RATE: target_r   <= cfg_wdata[RateW-1:0];
          CFG_RATE_TOL:    tol_r      <= cfg_wdata[RateW-1:0];
          CFG_MIN_INTV:    min_intv_r <= cfg_wdata[IntvW-1:0];
          default:         ;
        endcase
      end

      if (load_out) begin
        out_valid_r  <= 1'b1;
        seen_first_r <= 1'b1;
        fault_r      <= new_fault;
        if (store_r) begin
          last_count_r <= cur_count_r;
          last_time_r  <= cur_time_r;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_count_r <= in_frame_count;
      cur_time_r  <= in_timestamp_us;
      delta_r     <= in_frame_count - last_count_r;
      elapsed_r   <= in_timestamp_us - last_time_r;
    end

    if (check_step) begin
      meas_r  <= seen_first_r && intv_exceeded;
      store_r <= !seen_first_r || intv_exceeded;
      ovf_r   <= 1'b0;
      acc_r   <= '0;
      quo_r   <= '0;
      rem_r   <= '0;
      cnt_r   <= CntW'(UsPerSecW - 1);
    end

    // acc = acc*2 + (bit k of 1e6 ? delta : 0), k from MSB down
    if (mul_step) begin
      acc_r <= {acc_r[ProdW-2:0], 1'b0} +
               (UsPerSec[cnt_r] ? ProdW'(delta_r) : ProdW'(0));
      cnt_r <= cnt_r - CntW'(1);
    end

    if (ovf_step) begin
      ovf_r <= acc_ovf;
      rem_r <= acc_hi;
      dvd_r <= {acc_r[QuoW-FracW-1:0], {FracW{1'b0}}};
      cnt_r <= CntW'(QuoW - 1);
    end

    if (div_step) begin
      rem_r <= trial_ok ? trial[TimeW-1:0] : {rem_r[TimeW-2:0], dvd_r[QuoW-1]};
      quo_r <= {quo_r[QuoW-2:0], trial_ok};
      dvd_r <= {dvd_r[QuoW-2:0], 1'b0};
      cnt_r <= cnt_r - CntW'(1);
    end

    if (load_out) begin
      o_rate_valid_r <= meas_r;
      o_rate_r       <= meas_r ? rate_sat : '0;
      o_fault_r      <= new_fault;
      o_changed_r    <= new_fault != fault_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rate_valid    = o_rate_valid_r;
  assign out_measured_rate = o_rate_r;
  assign out_rate_fault    = o_fault_r;
  assign out_fault_changed = o_changed_r;

  // ---------------------------------------------------------------------
  // assertions
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_CHECK)
    else $error("accepted beat did not enter check");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_step |-> rem_r < elapsed_r)
    else $error("divider remainder not below divisor");

  a_mul_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    mul_step |-> cnt_r < CntW'(UsPerSecW))
    else $error("multiplier bit index out of range");

  a_rate_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rate_valid) |-> (out_measured_rate == '0) && !out_fault_changed)
    else $error("rate or fault change reported without measurement");

  a_fault_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_rate_fault == fault_r)
    else $error("reported fault differs from committed fault");

endmodule
